/* rtl/spse_pkg.sv */
// ----------------------------------------------------------------------------
// spse_pkg: shared types and constants of the sinusoid position encoder
// Opcodes, status codes, register indexes, item types, the CORDIC arctangent
// constants and the 48-bit saturation helper.
// ----------------------------------------------------------------------------
package spse_pkg;

	localparam int MAX_DIM      = 1024;
	localparam int CORDIC_STEPS = 16;
	localparam int ADDR_W       = $clog2(MAX_DIM);
	localparam int STEP_W       = $clog2(CORDIC_STEPS);

	typedef logic [1:0] opcode_t;
	localparam opcode_t OP_LOAD  = 2'd0;
	localparam opcode_t OP_CLEAR = 2'd1;
	localparam opcode_t OP_ACC   = 2'd2;
	localparam opcode_t OP_READ  = 2'd3;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_RANGE = 2'd1;
	localparam status_t ST_SAT   = 2'd2;

	localparam logic [1:0] CFG_VLEN   = 2'd0;
	localparam logic [1:0] CFG_BETA   = 2'd1;
	localparam logic [1:0] CFG_PSCALE = 2'd2;

	// 1/(2*pi) in Q0.32 and the CORDIC start value in Q1.30
	localparam logic [29:0]        INV_TWO_PI  = 30'd683565276;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	typedef struct packed {
		opcode_t             op;
		logic [9:0]          idx;
		logic signed [15:0]  elem;
		logic signed [31:0]  pos;
		logic signed [31:0]  freq;
		logic                refused;
	} item_t;

	typedef struct packed {
		logic [10:0]         vlen;
		logic signed [31:0]  beta;
		logic [15:0]         pscale;
	} cfg_t;

	typedef struct packed {
		logic init;
	} back_stat_t;

	typedef struct packed {
		logic               clip;
		logic signed [47:0] val;
	} sat_t;

	// arctangent of 2^-i in Q0.32 turns
	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000029;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000003;
			5'd29: r = 32'h00000001;
			5'd30: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

	// clip a 52-bit value to the signed 48-bit range
	function automatic sat_t sat48(input logic signed [51:0] v);
		sat_t r;
		if (!v[51] && (|v[50:47])) begin
			r.clip = 1'b1;
			r.val  = {1'b0, {47{1'b1}}};
		end else if (v[51] && !(&v[50:47])) begin
			r.clip = 1'b1;
			r.val  = {1'b1, {47{1'b0}}};
		end else begin
			r.clip = 1'b0;
			r.val  = v[47:0];
		end
		return r;
	endfunction

endpackage

/* rtl/spse_ram.sv */
// ----------------------------------------------------------------------------
// spse_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module spse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* rtl/spse_front.sv */
// ----------------------------------------------------------------------------
// spse_front: command intake and configuration registers
// Takes commands, checks the index against the vector length, holds config.
// ----------------------------------------------------------------------------
module spse_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  spse_pkg::opcode_t   opcode,
	input  logic [9:0]          index,
	input  logic signed [15:0]  element_value,
	input  logic signed [31:0]  position,
	input  logic signed [31:0]  frequency,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	output logic                push,
	output spse_pkg::item_t     entry,
	output spse_pkg::cfg_t      cfg
);
	import spse_pkg::*;

	logic [10:0]        vlen_q;
	logic signed [31:0] beta_q;
	logic [15:0]        pscale_q;
	logic               beyond;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vlen_q   <= 11'd1024;
			beta_q   <= 32'sd16777216;
			pscale_q <= 16'd2048;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_VLEN:   vlen_q   <= cfg_data[10:0];
				CFG_BETA:   beta_q   <= cfg_data;
				CFG_PSCALE: pscale_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// refuse indices past the vector length or the table depth
	assign beyond = ({1'b0, index} >= vlen_q) || ({22'b0, index} >= 32'(MAX_DIM));

	assign push          = start && !busy;
	assign entry.op      = opcode;
	assign entry.idx     = index;
	assign entry.elem    = element_value;
	assign entry.pos     = position;
	assign entry.freq    = frequency;
	assign entry.refused = (opcode != OP_CLEAR) && beyond;

	assign cfg.vlen   = vlen_q;
	assign cfg.beta   = beta_q;
	assign cfg.pscale = pscale_q;
endmodule

/* rtl/spse_queue.sv */
// ----------------------------------------------------------------------------
// spse_queue: two-entry command queue
// Decouples command intake from the execution sequencer.
// ----------------------------------------------------------------------------
module spse_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  spse_pkg::item_t wr_item,
	input  logic            pop,
	output spse_pkg::item_t head,
	output logic            empty,
	output logic            full
);
	import spse_pkg::*;

	item_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assign head  = slot_q[rd_ptr_q];
	assign empty = (count_q == 2'd0);
	assign full  = (count_q == 2'd2);
endmodule

/* rtl/spse_back.sv */
// ----------------------------------------------------------------------------
// spse_back: execution sequencer
// Runs one command at a time over a shared multiplier, a CORDIC and the RAMs.
// ----------------------------------------------------------------------------
module spse_back (
	input  logic                clk,
	input  logic                arst_n,
	input  spse_pkg::item_t     head,
	input  logic                q_empty,
	output logic                pop,
	input  spse_pkg::cfg_t      cfg,
	output spse_pkg::back_stat_t stat,
	output logic                done,
	output logic signed [47:0]  sin_result,
	output logic signed [47:0]  cos_result,
	output spse_pkg::status_t   status
);
	import spse_pkg::*;

	localparam logic [4:0] S_INIT = 5'd0,  S_IDLE = 5'd1,  S_FB   = 5'd2,  S_TL   = 5'd3;
	localparam logic [4:0] S_TH   = 5'd4,  S_T    = 5'd5,  S_P1   = 5'd6,  S_P2   = 5'd7;
	localparam logic [4:0] S_PH   = 5'd8,  S_CORD = 5'd9,  S_ROT  = 5'd10, S_A1   = 5'd11;
	localparam logic [4:0] S_A2   = 5'd12, S_A3   = 5'd13, S_A4   = 5'd14, S_A5   = 5'd15;
	localparam logic [4:0] S_RM   = 5'd16, S_RL   = 5'd17, S_RF   = 5'd18, S_CLR  = 5'd19;

	logic [4:0]          state_q;
	item_t               cur_q;
	logic [ADDR_W-1:0]   clr_q;
	logic [STEP_W-1:0]   cnt_q;
	logic [2:0]          k_q;
	logic signed [65:0]  prod_q;
	logic signed [32:0]  mul_a, mul_b;
	logic signed [47:0]  a_q, b_q;
	logic [31:0]         fb_hi_q;
	logic                fb_neg_q;
	logic [31:0]         tmp_q, tmp2_q;
	logic [63:0]         t_q;
	logic [1:0]          quad_q;
	logic signed [33:0]  x_q, y_q, z_q;
	logic signed [31:0]  sn_q, cs_q;
	logic signed [33:0]  ts_q;
	logic signed [81:0]  sum_s_q, sum_c_q;

	logic [31:0]         freq_rd;
	logic [47:0]         sacc_rd, cacc_rd;
	logic                f_we, acc_we, sweeping;
	logic [ADDR_W-1:0]   acc_waddr, raddr;
	logic [47:0]         s_wdata, c_wdata;

	logic [31:0]         ph, qp, rr;
	logic [1:0]          quad;
	logic signed [33:0]  sx, sy, at;
	logic signed [33:0]  tc_w;
	logic signed [48:0]  s_sum, c_sum;
	sat_t                s_sat, c_sat, rs_sat, rc_sat;
	logic signed [47:0]  rm_word;
	logic signed [32:0]  rm_a, rm_b, nsn;
	logic [2:0]          kp;
	logic signed [81:0]  term;

	assign raddr = ADDR_W'(head.idx);

	spse_ram #(.WIDTH(32), .DEPTH(MAX_DIM)) u_freq (
		.clk(clk), .we(f_we), .waddr(raddr), .wdata(head.freq),
		.raddr(raddr), .rdata(freq_rd)
	);
	spse_ram #(.WIDTH(48), .DEPTH(MAX_DIM)) u_sacc (
		.clk(clk), .we(acc_we), .waddr(acc_waddr), .wdata(s_wdata),
		.raddr(raddr), .rdata(sacc_rd)
	);
	spse_ram #(.WIDTH(48), .DEPTH(MAX_DIM)) u_cacc (
		.clk(clk), .we(acc_we), .waddr(acc_waddr), .wdata(c_wdata),
		.raddr(raddr), .rdata(cacc_rd)
	);

	assign pop      = (state_q == S_IDLE) && !q_empty;
	assign f_we     = pop && (head.op == OP_LOAD) && !head.refused;
	assign sweeping = (state_q == S_INIT) || (state_q == S_CLR);
	assign acc_we   = sweeping || (state_q == S_A5);
	assign acc_waddr = sweeping ? clr_q : ADDR_W'(cur_q.idx);
	assign stat.init = (state_q == S_INIT);

	// phase top word, quadrant and residue
	assign ph   = tmp_q + prod_q[31:0] - (cur_q.pos[31] ? t_q[31:0] : 32'd0);
	assign qp   = ph + 32'h4000_0000;
	assign quad = qp[31:30];
	assign rr   = ph - {quad, 30'b0};

	assign sx = x_q >>> cnt_q;
	assign sy = y_q >>> cnt_q;
	assign at = {2'b00, atan_turn(5'(cnt_q))};

	// accumulate update with saturation
	assign tc_w    = prod_q[47:14];
	assign s_sum   = {a_q[47], a_q} + {{15{ts_q[33]}}, ts_q};
	assign c_sum   = {b_q[47], b_q} + {{15{tc_w[33]}}, tc_w};
	assign s_sat   = sat48({{3{s_sum[48]}}, s_sum});
	assign c_sat   = sat48({{3{c_sum[48]}}, c_sum});
	assign s_wdata = sweeping ? 48'd0 : s_sat.val;
	assign c_wdata = sweeping ? 48'd0 : c_sat.val;

	// read rotation: eight partial products over 24-bit halves
	assign nsn     = -{sn_q[31], sn_q};
	assign rm_word = (k_q[2] ^ k_q[1]) ? b_q : a_q;
	assign rm_a    = k_q[0] ? {9'b0, rm_word[23:0]} : {{9{rm_word[47]}}, rm_word[47:24]};
	always_comb begin
		case (k_q[2:1])
			2'b01:   rm_b = {sn_q[31], sn_q};
			2'b11:   rm_b = nsn;
			default: rm_b = {cs_q[31], cs_q};
		endcase
	end
	assign kp   = (state_q == S_RL) ? 3'd7 : k_q - 3'd1;
	assign term = kp[0] ? {{16{prod_q[65]}}, prod_q}
	                    : ({{16{prod_q[65]}}, prod_q} <<< 24);
	assign rs_sat = sat48(sum_s_q[81:30]);
	assign rc_sat = sat48(sum_c_q[81:30]);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_FB: begin
				mul_a = {freq_rd[31], freq_rd};
				mul_b = {cfg.beta[31], cfg.beta};
			end
			S_TL: begin
				mul_a = {1'b0, prod_q[31:0]};
				mul_b = {3'b0, INV_TWO_PI};
			end
			S_TH: begin
				mul_a = {1'b0, fb_hi_q};
				mul_b = {3'b0, INV_TWO_PI};
			end
			S_P1: begin
				mul_a = {1'b0, t_q[31:0]};
				mul_b = {1'b0, cur_q.pos};
			end
			S_P2: begin
				mul_a = {1'b0, t_q[63:32]};
				mul_b = {1'b0, cur_q.pos};
			end
			S_A1: begin
				mul_a = {sn_q[31], sn_q};
				mul_b = {17'b0, cfg.pscale};
			end
			S_A2: begin
				mul_a = {cs_q[31], cs_q};
				mul_b = {17'b0, cfg.pscale};
			end
			S_A3: begin
				mul_a = {tmp_q[31], tmp_q};
				mul_b = {{17{cur_q.elem[15]}}, cur_q.elem};
			end
			S_A4: begin
				mul_a = {tmp2_q[31], tmp2_q};
				mul_b = {{17{cur_q.elem[15]}}, cur_q.elem};
			end
			S_RM: begin
				mul_a = rm_a;
				mul_b = rm_b;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			clr_q   <= '0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_INIT, S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(MAX_DIM - 1)) begin
						clr_q <= '0;
						if (state_q == S_CLR) begin
							done <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (!q_empty) begin
						if (head.op == OP_CLEAR) begin
							state_q <= S_CLR;
						end else if (head.refused || head.op == OP_LOAD) begin
							done <= 1'b1;
						end else begin
							state_q <= S_FB;
						end
					end
				end
				S_FB:   state_q <= S_TL;
				S_TL:   state_q <= S_TH;
				S_TH:   state_q <= S_T;
				S_T:    state_q <= S_P1;
				S_P1:   state_q <= S_P2;
				S_P2:   state_q <= S_PH;
				S_PH:   state_q <= S_CORD;
				S_CORD: begin
					if (cnt_q == STEP_W'(CORDIC_STEPS - 1)) begin
						state_q <= S_ROT;
					end
				end
				S_ROT:  state_q <= (cur_q.op == OP_ACC) ? S_A1 : S_RM;
				S_A1:   state_q <= S_A2;
				S_A2:   state_q <= S_A3;
				S_A3:   state_q <= S_A4;
				S_A4:   state_q <= S_A5;
				S_A5: begin
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				S_RM: begin
					if (k_q == 3'd7) begin
						state_q <= S_RL;
					end
				end
				S_RL:   state_q <= S_RF;
				S_RF: begin
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cur_q      <= head;
				sin_result <= '0;
				cos_result <= '0;
				status     <= head.refused ? ST_RANGE : ST_OK;
			end
			S_CLR: begin
				sin_result <= '0;
				cos_result <= '0;
				status     <= ST_OK;
			end
			S_FB: begin
				a_q <= sacc_rd;
				b_q <= cacc_rd;
			end
			S_TL: begin
				fb_hi_q  <= prod_q[63:32];
				fb_neg_q <= prod_q[63];
			end
			S_TH:   tmp_q <= prod_q[63:32];
			S_T:    t_q <= prod_q[63:0] + {32'b0, tmp_q}
			               - (fb_neg_q ? {2'b0, INV_TWO_PI, 32'b0} : 64'd0);
			S_P2:   tmp_q <= prod_q[63:32];
			S_PH: begin
				quad_q <= quad;
				x_q    <= CORDIC_GAIN;
				y_q    <= '0;
				z_q    <= {{2{rr[31]}}, rr};
				cnt_q  <= '0;
			end
			S_CORD: begin
				cnt_q <= cnt_q + 1'b1;
				if (!z_q[33]) begin
					x_q <= x_q - sy;
					y_q <= y_q + sx;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + sy;
					y_q <= y_q - sx;
					z_q <= z_q + at;
				end
			end
			S_ROT: begin
				k_q     <= '0;
				sum_s_q <= '0;
				sum_c_q <= '0;
				case (quad_q)
					2'd0: begin cs_q <= x_q[31:0];    sn_q <= y_q[31:0];    end
					2'd1: begin cs_q <= -y_q[31:0];   sn_q <= x_q[31:0];    end
					2'd2: begin cs_q <= -x_q[31:0];   sn_q <= -y_q[31:0];   end
					default: begin cs_q <= y_q[31:0]; sn_q <= -x_q[31:0];   end
				endcase
			end
			S_A2:   tmp_q  <= prod_q[47:16];
			S_A3:   tmp2_q <= prod_q[47:16];
			S_A4:   ts_q   <= prod_q[47:14];
			S_A5: begin
				sin_result <= '0;
				cos_result <= '0;
				status     <= (s_sat.clip || c_sat.clip) ? ST_SAT : ST_OK;
			end
			S_RM, S_RL: begin
				k_q <= k_q + 3'd1;
				if (state_q == S_RL || k_q != 3'd0) begin
					if (kp[2]) sum_c_q <= sum_c_q + term;
					else       sum_s_q <= sum_s_q + term;
				end
			end
			S_RF: begin
				sin_result <= rs_sat.val;
				cos_result <= rc_sat.val;
				status     <= (rs_sat.clip || rc_sat.clip) ? ST_SAT : ST_OK;
			end
			default: ;
		endcase
	end

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == S_IDLE))
		else $error("queue popped outside idle");
	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_RANGE) |-> (sin_result == '0 && cos_result == '0))
		else $error("refused command returned data");
	a_no_acc_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !acc_we)
		else $error("accumulator written while idle");
	a_cord_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROT) |-> ($past(state_q) == S_CORD))
		else $error("rotation entered without CORDIC");
endmodule

/* rtl/sinusoid_position_sequence_encoder_unit.sv */
// ----------------------------------------------------------------------------
// sinusoid_position_sequence_encoder_unit: sinusoid position sequence encoder
// Per-dimension frequency table with paired sine/cosine accumulators.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on start/busy: a beat is taken on a rising edge with start
//   high and busy low. A two-entry queue sits between intake and execution,
//   so up to two commands may be taken while one is being worked on.
//   Each command gives one result beat: done is high for one cycle with
//   sin_result, cos_result and status. The receiver cannot stall; results are
//   simply presented for that cycle.
//   Once the sequencer picks up a command, a load or a refused index is done
//   straight from idle; accumulate and read run 16 CORDIC steps plus
//   multiplies through one shared 33x33 multiplier; clear walks both
//   accumulator RAMs. The sequencer works on one command at a time.
//   After reset a clearing pass over all MAX_DIM entries zeroes the accumulator
//   RAMs; busy is held high meanwhile. Config writes (cfg_we) are taken at any
//   time and are meant only while the unit is idle.
// ----------------------------------------------------------------------------
module sinusoid_position_sequence_encoder_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  spse_pkg::opcode_t   opcode,
	input  logic [9:0]          index,
	input  logic signed [15:0]  element_value,
	input  logic signed [31:0]  position,
	input  logic signed [31:0]  frequency,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	output logic                done,
	output logic signed [47:0]  sin_result,
	output logic signed [47:0]  cos_result,
	output spse_pkg::status_t   status
);
	import spse_pkg::*;

	logic       push, pop, q_empty, q_full;
	item_t      entry, head;
	cfg_t       cfg;
	back_stat_t bstat;

	// hold off intake when the queue is full or the reset clearing pass runs
	assign busy = q_full || bstat.init;

	spse_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .index(index), .element_value(element_value),
		.position(position), .frequency(frequency),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.push(push), .entry(entry), .cfg(cfg)
	);

	spse_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .wr_item(entry),
		.pop(pop), .head(head), .empty(q_empty), .full(q_full)
	);

	spse_back u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .q_empty(q_empty), .pop(pop),
		.cfg(cfg), .stat(bstat), .done(done), .sin_result(sin_result),
		.cos_result(cos_result), .status(status)
	);
endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the sinusoid position sequence encoder
// Feeds frequency loads, clears, accumulates and shifted reads through the
// start/busy port, predicts every result beat with a bit-exact fixed-point
// model of the encoder and compares each done beat against it in order.
// ----------------------------------------------------------------------------
module tb;
	import spse_pkg::*;

	localparam int ACC_W = 48;

	typedef struct {
		opcode_t            op;
		logic [9:0]         idx;
		logic signed [15:0] elem;
		logic signed [31:0] pos;
		logic signed [31:0] freq;
	} cmd_t;

	typedef struct {
		logic signed [47:0] sn;
		logic signed [47:0] cs;
		status_t            st;
	} answer_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	opcode_t            opcode = OP_LOAD;
	logic [9:0]         index = '0;
	logic signed [15:0] element_value = '0;
	logic signed [31:0] position = '0;
	logic signed [31:0] frequency = '0;
	logic               cfg_we = 1'b0;
	logic [1:0]         cfg_index = '0;
	logic [31:0]        cfg_data = '0;
	logic               done;
	logic signed [47:0] sin_result;
	logic signed [47:0] cos_result;
	status_t            status;

	sinusoid_position_sequence_encoder_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .index(index), .element_value(element_value),
		.position(position), .frequency(frequency),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .sin_result(sin_result), .cos_result(cos_result),
		.status(status)
	);

	// Predictor state: a private copy of the encoder's tables and registers
	logic [10:0]        p_vlen;
	logic signed [63:0] p_beta;
	logic [15:0]        p_pscale;
	logic signed [31:0] freq_tab [MAX_DIM];
	logic signed [63:0] sin_acc [MAX_DIM];
	logic signed [63:0] cos_acc [MAX_DIM];
	bit                 freq_known [MAX_DIM];

	cmd_t    pending_cmds [$];
	answer_t expected_beats [$];
	int      failures = 0;
	int      beats_seen = 0;
	int      n_op [4] = '{0, 0, 0, 0};
	int      n_sat = 0;
	int      n_range = 0;

	// floor division by 2^s on a signed 128-bit value
	function automatic logic signed [127:0] fshift(input logic signed [127:0] v, input int s);
		return v >>> s;
	endfunction

	function automatic logic signed [63:0] clip48(input logic signed [127:0] v, inout bit c);
		logic signed [127:0] hi, lo;
		hi = (128'sd1 <<< 47) - 1;
		lo = -(128'sd1 <<< 47);
		if (v > hi) begin c = 1; return hi[63:0]; end
		if (v < lo) begin c = 1; return lo[63:0]; end
		return v[63:0];
	endfunction

	// unit sine and cosine (Q1.30) of freq * beta * pos
	task automatic unit_sincos(input logic signed [31:0] fr, input logic signed [31:0] ps,
			output logic signed [63:0] sn, output logic signed [63:0] cs);
		logic signed [63:0] fb, x, y, z, nx, ny;
		logic [63:0] u, t, pu;
		logic [127:0] prod;
		logic [31:0] ph, rr;
		logic [1:0] q;
		fb = 64'(fr) * p_beta;
		u = fb;
		t = u[63:32] * 64'd683565276 + ((u[31:0] * 64'd683565276) >> 32);
		if (fb < 0) t = t - (64'd683565276 << 32);
		pu = 64'(ps);
		prod = t * pu;
		ph = prod[63:32];
		q = 2'((ph + 32'h40000000) >> 30);
		rr = ph - (32'(q) << 30);
		z = 64'(signed'(rr));
		x = 64'sd652032874;
		y = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z = z - 64'(atan_turn(5'(i)));
			end else begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z = z + 64'(atan_turn(5'(i)));
			end
			x = nx;
			y = ny;
		end
		case (q)
			2'd0: begin cs = x; sn = y; end
			2'd1: begin cs = -y; sn = x; end
			2'd2: begin cs = -x; sn = -y; end
			default: begin cs = y; sn = -x; end
		endcase
	endtask

	// work out the result of one accepted command and advance the model
	task automatic predict_encoder(input cmd_t c);
		answer_t a;
		logic signed [63:0] sn, cs;
		logic signed [127:0] ts, tc;
		bit clipped;
		clipped = 0;
		a.sn = 0; a.cs = 0; a.st = ST_OK;
		n_op[c.op]++;
		if (c.op == OP_CLEAR) begin
			for (int i = 0; i < MAX_DIM; i++) begin
				sin_acc[i] = 0;
				cos_acc[i] = 0;
			end
		end else if (c.idx >= p_vlen) begin
			a.st = ST_RANGE;
		end else if (c.op == OP_LOAD) begin
			freq_tab[c.idx] = c.freq;
			freq_known[c.idx] = 1;
		end else if (c.op == OP_ACC) begin
			unit_sincos(freq_tab[c.idx], c.pos, sn, cs);
			ts = fshift(fshift(128'(sn) * 128'(signed'({1'b0, p_pscale})), 16)
				* 128'(c.elem), 14);
			tc = fshift(fshift(128'(cs) * 128'(signed'({1'b0, p_pscale})), 16)
				* 128'(c.elem), 14);
			sin_acc[c.idx] = clip48(128'(sin_acc[c.idx]) + ts, clipped);
			cos_acc[c.idx] = clip48(128'(cos_acc[c.idx]) + tc, clipped);
			if (clipped) a.st = ST_SAT;
		end else begin
			unit_sincos(freq_tab[c.idx], c.pos, sn, cs);
			a.sn = 48'(clip48(fshift(128'(sin_acc[c.idx]) * 128'(cs)
				+ 128'(cos_acc[c.idx]) * 128'(sn), 30), clipped));
			a.cs = 48'(clip48(fshift(128'(cos_acc[c.idx]) * 128'(cs)
				- 128'(sin_acc[c.idx]) * 128'(sn), 30), clipped));
			if (clipped) a.st = ST_SAT;
		end
		if (a.st == ST_SAT) n_sat++;
		if (a.st == ST_RANGE) n_range++;
		expected_beats.push_back(a);
	endtask

	initial begin
		forever #2 clk = ~clk;
	end

	// Driver: present the oldest pending command, hold it until busy is low
	// at an edge, then drop start for a random gap, which may be empty.
	int gap_left = 0;
	always @(posedge clk) begin
		if (start && busy) begin
			// hold the current beat
		end else begin
			if (start) begin
				predict_encoder(pending_cmds.pop_front());
				gap_left = $urandom_range(0, 5);
			end
			if (gap_left > 0) begin
				start <= 1'b0;
				gap_left = gap_left - 1;
			end else if (pending_cmds.size() > 0) begin
				start <= 1'b1;
				opcode <= pending_cmds[0].op;
				index <= pending_cmds[0].idx;
				element_value <= pending_cmds[0].elem;
				position <= pending_cmds[0].pos;
				frequency <= pending_cmds[0].freq;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: every done beat must match the oldest expectation
	always @(posedge clk) begin
		if (done) begin
			beats_seen++;
			if (expected_beats.size() == 0) begin
				$display("%0t: result beat with nothing expected", $time);
				failures++;
			end else begin
				answer_t e;
				e = expected_beats.pop_front();
				if (sin_result !== e.sn) begin
					$display("%0t: sin_result expected %0d got %0d", $time, e.sn, sin_result);
					failures++;
				end
				if (cos_result !== e.cs) begin
					$display("%0t: cos_result expected %0d got %0d", $time, e.cs, cos_result);
					failures++;
				end
				if (status !== e.st) begin
					$display("%0t: status expected %0d got %0d", $time, e.st, status);
					failures++;
				end
			end
		end
	end

	function automatic cmd_t mk(input opcode_t op, input int idx, input int elem,
			input logic [31:0] pos, input logic [31:0] fr);
		cmd_t c;
		c.op = op; c.idx = 10'(idx); c.elem = 16'(elem); c.pos = pos; c.freq = fr;
		return c;
	endfunction

	// random loaded index below vlen (else 0), drawn now and then from the whole table
	function automatic int pick_idx();
		int k;
		for (int n = 0; n < 40; n++) begin
			k = (p_vlen > 16 && $urandom_range(0, 3) != 0) ? $urandom_range(0, 15)
				: $urandom_range(0, 1023);
			if (k < p_vlen && freq_known[k]) return k;
		end
		return 0;
	endfunction

	function automatic logic [31:0] rnd_pos();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'($urandom_range(0, 16)) << 16;
			2: return -(32'($urandom_range(0, 255)) << 16);
			default: return 32'(signed'(16'($urandom)));
		endcase
	endfunction

	function automatic logic [15:0] rnd_elem();
		case ($urandom_range(0, 3))
			0: return 16'h7FFF;
			1: return 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic write_reg(input logic [1:0] r, input logic [31:0] v);
		@(posedge clk);
		cfg_we <= 1'b1; cfg_index <= r; cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (r)
			CFG_VLEN:   p_vlen = v[10:0];
			CFG_BETA:   p_beta = 64'(signed'(v));
			default:    p_pscale = v[15:0];
		endcase
	endtask

	// let everything queued drain and the sequencer fall quiet
	task automatic drain();
		wait (pending_cmds.size() == 0 && !start && expected_beats.size() == 0);
		repeat (40) @(posedge clk);
		wait (!busy);
	endtask

	task automatic random_phase(input int count);
		int k;
		for (int n = 0; n < count; n++) begin
			k = $urandom_range(0, 99);
			if (k < 6) pending_cmds.push_back(mk(OP_LOAD, $urandom_range(0, 1023), 0, 0, $urandom));
			else if (k < 8) pending_cmds.push_back(mk(OP_CLEAR, $urandom_range(0, 1023), 0, 0, 0));
			else if (k < 60) pending_cmds.push_back(mk(OP_ACC, pick_idx(), rnd_elem(), rnd_pos(), 0));
			else if (k < 95) pending_cmds.push_back(mk(OP_READ, pick_idx(), 0, rnd_pos(), 0));
			else pending_cmds.push_back(mk(OP_READ, 1023, 0, $urandom, 0));
		end
		drain();
	endtask

	initial begin
		p_vlen = 11'd1024; p_beta = 64'sd16777216; p_pscale = 16'd2048;
		for (int i = 0; i < MAX_DIM; i++) begin
			freq_tab[i] = 0; sin_acc[i] = 0; cos_acc[i] = 0; freq_known[i] = 0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		// the post-reset clearing pass holds busy; wait it out
		repeat (2) @(posedge clk);
		wait (!busy);

		// Directed: extremes of every field, each operation, refused index
		for (int i = 0; i < 16; i++)
			pending_cmds.push_back(mk(OP_LOAD, i, 0, 0, $urandom));
		pending_cmds.push_back(mk(OP_LOAD, 1023, 0, 0, 32'h7FFFFFFF));
		pending_cmds.push_back(mk(OP_LOAD, 0, 0, 0, 32'h80000000));
		pending_cmds.push_back(mk(OP_ACC, 0, 16'h7FFF, 32'h7FFFFFFF, 0));
		pending_cmds.push_back(mk(OP_ACC, 1023, 16'h8000, 32'h80000000, 0));
		pending_cmds.push_back(mk(OP_READ, 0, 16'hFFFF, 32'hFFFFFFFF, 0));
		pending_cmds.push_back(mk(OP_READ, 1023, 0, 32'h00010000, 0));
		pending_cmds.push_back(mk(OP_CLEAR, 1023, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
		pending_cmds.push_back(mk(OP_READ, 0, 0, 0, 0));
		drain();
		write_reg(CFG_VLEN, 32'd8);
		pending_cmds.push_back(mk(OP_ACC, 8, 100, 5, 0));
		pending_cmds.push_back(mk(OP_LOAD, 1023, 0, 0, 1));
		pending_cmds.push_back(mk(OP_READ, 9, 0, 0, 0));
		drain();

		// Random phases across register settings, extremes included
		write_reg(CFG_PSCALE, 32'hFFFF);
		write_reg(CFG_BETA, 32'h7FFFFFFF);
		write_reg(CFG_VLEN, 32'd1024);
		random_phase(200);
		write_reg(CFG_BETA, 32'h80000000);
		write_reg(CFG_PSCALE, 32'd0);
		write_reg(CFG_VLEN, 32'd1);
		random_phase(100);
		write_reg(CFG_BETA, $urandom);
		write_reg(CFG_PSCALE, $urandom);
		write_reg(CFG_VLEN, 32'd12);
		random_phase(200);
		write_reg(CFG_BETA, 32'd16777216);
		write_reg(CFG_PSCALE, 32'hFFFF);
		write_reg(CFG_VLEN, 32'd1024);
		// saturating phase: pile large terms into few entries
		for (int n = 0; n < 150; n++)
			pending_cmds.push_back(mk($urandom_range(0, 4) ? OP_ACC : OP_READ,
				$urandom_range(0, 2), $urandom_range(0, 1) ? 16'h7FFF : 16'h8000, rnd_pos(), 0));
		drain();
		write_reg(CFG_BETA, 32'h00400000);
		write_reg(CFG_PSCALE, 32'd2048);
		random_phase(200);

		$display("Covered %0d loads, %0d clears, %0d accumulates, %0d reads (%0d beats).",
			n_op[OP_LOAD], n_op[OP_CLEAR], n_op[OP_ACC], n_op[OP_READ], beats_seen);
		$display("Refused indexes: %0d, saturated results: %0d.", n_range, n_sat);
		if (failures == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("FAILURE");
		$finish;
	end

endmodule

/* sinusoid_position_sequence_encoder_unit.f */
rtl/spse_pkg.sv
rtl/spse_ram.sv
rtl/spse_front.sv
rtl/spse_queue.sv
rtl/spse_back.sv
rtl/sinusoid_position_sequence_encoder_unit.sv
tb/sv/tb.sv
